>>> hdl/rate_limited_priority_prompt_scheduler_assert.svh
// Assertion macros used by the prompt scheduler checker
`ifndef RATE_LIMITED_PRIORITY_PROMPT_SCHEDULER_ASSERT_SVH
`define RATE_LIMITED_PRIORITY_PROMPT_SCHEDULER_ASSERT_SVH

// Clocked property, ignored while reset is high.
`define RLPPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same-cycle implication, ignored while reset is high.
`define RLPPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hdl/rlpps_pkg.sv
// Types and constants of the prompt scheduler
package rlpps_pkg;

   // item operation codes
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd1000;
   localparam logic [16:0] ELAPSED_MAX           = 17'h1FFFF;

   typedef enum logic [2:0] {
      STAT_RATE_LIMITED = 3'd0,
      STAT_STARTED      = 3'd1,
      STAT_PREEMPTED    = 3'd2,
      STAT_QUEUED       = 3'd3,
      STAT_QUEUE_FULL   = 3'd4,
      STAT_TICK_CONT    = 3'd5,
      STAT_TICK_NEXT    = 3'd6,
      STAT_TICK_IDLE    = 3'd7
   } status_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [3:0]  prio;
      logic [15:0] duration;
      logic [15:0] tag;
   } prompt_type;

endpackage

>>> hdl/rate_limited_priority_prompt_scheduler.sv
// Rate-limited priority prompt scheduler, top level
//
// Schedules spoken prompts, one playing at a time. A request word (operation 0)
// carries kind, priority, duration and tag; kinds below LIMITED_KINDS are
// refused if the same kind was accepted less than csr_wr_data milliseconds ago
// (reset value 1000 ms, zero disables the limit). An idle block starts the
// prompt, a strictly higher priority preempts the playing one (which is
// discarded), otherwise the prompt waits in a FIFO_DEPTH-deep FIFO or is
// dropped when that is full. A tick word (operation 1) adds delta_ms to the
// 32-bit global time (wrapping) and to the playing prompt's elapsed time; once
// elapsed reaches the duration the FIFO head starts or the block goes idle.
// Every word gives exactly one result word. The decision is made in
// the cycle a word is accepted and the result word is registered, so it shows
// in the next cycle; a new word is taken every cycle, limited only by the result
// register, which frees when rsp_ready is high. The FIFO is a small memory
// with a registered head read, written and read in the same clock.
// The repeat interval may only be written while no word is in flight.
module rate_limited_priority_prompt_scheduler #(
   parameter int FIFO_DEPTH    = 4,
   parameter int LIMITED_KINDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [3:0]  req_prompt_kind,
   input  logic [3:0]  req_prompt_priority,
   input  logic [15:0] req_prompt_duration_ms,
   input  logic [15:0] req_prompt_tag,
   input  logic [15:0] req_delta_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_playing,
   output logic [3:0]  rsp_current_kind,
   output logic [3:0]  rsp_current_priority,
   output logic [15:0] rsp_current_tag,
   output logic [2:0]  rsp_waiting_count,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import rlpps_pkg::*;

   localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam int KIND_W = (LIMITED_KINDS > 1) ? $clog2(LIMITED_KINDS) : 1;
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);
   localparam logic [4:0]        KIND_LIM  = 5'(LIMITED_KINDS);

   // configuration and time
   logic [15:0]              interval_ff;
   logic [31:0]              global_time_ff, global_time_in;

   // per-kind stamps; stamp only meaningful when its valid bit is set
   logic [31:0]              stamp_ff [LIMITED_KINDS];
   logic [LIMITED_KINDS-1:0] stamp_valid_ff;
   logic                     stamp_we;

   // playing prompt
   logic                     busy_ff, busy_in;
   prompt_type               active_ff, active_in;
   logic [16:0]              elapsed_ff, elapsed_in;

   // wait FIFO
   prompt_type               fifo_mem [FIFO_DEPTH];
   prompt_type               head_data_ff;
   logic [PTR_W-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic                     push, pop;

   // result register
   logic                     rsp_valid_ff;
   status_type               status_ff, status_in;
   logic                     playing_ff;
   logic [3:0]               cur_kind_ff, cur_prio_ff;
   logic [15:0]              cur_tag_ff;
   logic [2:0]               waiting_ff;

   // datapath
   logic                     accept;
   prompt_type               req_prompt;
   logic                     limited_kind;
   logic [KIND_W-1:0]        kind_idx;
   logic [31:0]              since_stamp;
   logic                     refused;
   logic [17:0]              elapsed_sum;
   logic [16:0]              elapsed_sat;
   logic                     prompt_done;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      ptr_inc = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign req_prompt = '{kind:     req_prompt_kind,
                         prio:     req_prompt_priority,
                         duration: req_prompt_duration_ms,
                         tag:      req_prompt_tag};

   // rate limit check
   assign limited_kind = {1'b0, req_prompt_kind} < KIND_LIM;
   assign kind_idx     = req_prompt_kind[KIND_W-1:0];
   assign since_stamp  = global_time_ff - stamp_ff[kind_idx];
   assign refused      = limited_kind && stamp_valid_ff[kind_idx] &&
                         (since_stamp < {16'd0, interval_ff});

   // elapsed time, saturating at 17 bits
   assign elapsed_sum = {1'b0, elapsed_ff} + {2'b00, req_delta_ms};
   assign elapsed_sat = elapsed_sum[17] ? ELAPSED_MAX : elapsed_sum[16:0];
   assign prompt_done = elapsed_sat >= {1'b0, active_ff.duration};

   always_comb begin
      global_time_in = global_time_ff;
      busy_in        = busy_ff;
      active_in      = active_ff;
      elapsed_in     = elapsed_ff;
      stamp_we       = 1'b0;
      push           = 1'b0;
      pop            = 1'b0;
      status_in      = STAT_TICK_CONT;

      if (accept) begin
         if (req_operation == OP_TICK) begin
            global_time_in = global_time_ff + {16'd0, req_delta_ms};
            if (!busy_ff) begin
               status_in = STAT_TICK_CONT;
            end else if (!prompt_done) begin
               elapsed_in = elapsed_sat;
               status_in  = STAT_TICK_CONT;
            end else if (fill_ff != '0) begin
               pop        = 1'b1;
               active_in  = head_data_ff;
               elapsed_in = '0;
               status_in  = STAT_TICK_NEXT;
            end else begin
               busy_in    = 1'b0;
               active_in  = '0;
               elapsed_in = '0;
               status_in  = STAT_TICK_IDLE;
            end
         end else if (refused) begin
            status_in = STAT_RATE_LIMITED;
         end else begin
            stamp_we = limited_kind;
            if (!busy_ff) begin
               busy_in    = 1'b1;
               active_in  = req_prompt;
               elapsed_in = '0;
               status_in  = STAT_STARTED;
            end else if (req_prompt_priority > active_ff.prio) begin
               active_in  = req_prompt;
               elapsed_in = '0;
               status_in  = STAT_PREEMPTED;
            end else if (fill_ff != FILL_FULL) begin
               push      = 1'b1;
               status_in = STAT_QUEUED;
            end else begin
               status_in = STAT_QUEUE_FULL;
            end
         end
      end
   end

   assign head_in = pop  ? ptr_inc(head_ff) : head_ff;
   assign tail_in = push ? ptr_inc(tail_ff) : tail_ff;
   assign fill_in = fill_ff + FILL_W'(push) - FILL_W'(pop);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= REPEAT_INTERVAL_RESET;
         global_time_ff <= '0;
         stamp_valid_ff <= '0;
         busy_ff        <= 1'b0;
         active_ff      <= '0;
         elapsed_ff     <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         global_time_ff <= global_time_in;
         if (stamp_we) begin
            stamp_valid_ff[kind_idx] <= 1'b1;
         end
         busy_ff    <= busy_in;
         active_ff  <= active_in;
         elapsed_ff <= elapsed_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stamps, no reset
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_ff[kind_idx] <= global_time_ff;
      end
   end

   // FIFO memory with registered head read; a push into an empty FIFO
   // lands on the head address and is forwarded
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[tail_ff] <= req_prompt;
      end
      if (push && (tail_ff == head_in)) begin
         head_data_ff <= req_prompt;
      end else begin
         head_data_ff <= fifo_mem[head_in];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         playing_ff  <= busy_in;
         cur_kind_ff <= active_in.kind;
         cur_prio_ff <= active_in.prio;
         cur_tag_ff  <= active_in.tag;
         waiting_ff  <= 3'(fill_in);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_playing          = playing_ff;
   assign rsp_current_kind     = cur_kind_ff;
   assign rsp_current_priority = cur_prio_ff;
   assign rsp_current_tag      = cur_tag_ff;
   assign rsp_waiting_count    = waiting_ff;

endmodule

>>> hdl/rlpps_checker.sv
// Port-level checker for the prompt scheduler, bound to the top level
`include "rate_limited_priority_prompt_scheduler_assert.svh"

module rlpps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_playing,
   input logic [3:0]  rsp_current_kind,
   input logic [3:0]  rsp_current_priority,
   input logic [15:0] rsp_current_tag,
   input logic [2:0]  rsp_waiting_count
);
   import rlpps_pkg::*;

   // a stalled result word is held
   `RLPPS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "rsp dropped while stalled")

   // every accepted word yields a result word next cycle
   `RLPPS_ASSERT(a_one_result, clock, reset, (req_valid && req_ready) |=> rsp_valid, "no result after accept")

   // idle means nothing current and nothing waiting
   `RLPPS_ASSERT_IMPLY(a_idle_clear, clock, reset, rsp_valid && !rsp_playing, (rsp_current_kind == 4'd0) && (rsp_current_priority == 4'd0) && (rsp_current_tag == 16'd0) && (rsp_waiting_count == 3'd0), "idle result not clear")

   // statuses that start or queue a prompt leave one playing
   `RLPPS_ASSERT_IMPLY(a_start_plays, clock, reset, rsp_valid && ((rsp_status == STAT_STARTED) || (rsp_status == STAT_PREEMPTED) || (rsp_status == STAT_TICK_NEXT) || (rsp_status == STAT_QUEUED)), rsp_playing, "start status without playing")

   // going idle leaves nothing playing
   `RLPPS_ASSERT_IMPLY(a_idle_status, clock, reset, rsp_valid && (rsp_status == STAT_TICK_IDLE), !rsp_playing, "went idle but playing")

endmodule

bind rate_limited_priority_prompt_scheduler rlpps_checker u_rlpps_checker (.*);
